// ===== design/rmsn_pkg.sv =====
// Shared types and constants for the RMS row normalizer.
// No dependencies; imported by the divide/root unit and the top level.
package rmsn_pkg;

   // Fixed widths of the datapath.
   localparam int SUM_W    = 44;
   localparam int EPS_W    = 24;
   localparam int SCALE_W  = 32;
   localparam int WEIGHT_W = 16;
   localparam int MEAN_W   = 45;
   localparam int NUM_W    = 58;
   localparam int REM_W    = 60;

   // Operation codes of the shared divide/root unit.
   localparam logic OP_DIV  = 1'b0;
   localparam logic OP_SQRT = 1'b1;

   // Command word from the sequencer to the shared unit.
   typedef struct packed {
      logic start;
      logic op;
   } rmsn_cmd_type;

endpackage

// ===== design/rmsn_root_div_unit.sv =====
// Shared iterative unit: restoring division (one quotient bit per cycle)
// and digit-by-digit integer square root (one root bit per cycle).
// Depends on rmsn_pkg.
module rmsn_root_div_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  rmsn_pkg::rmsn_cmd_type     cmd,
   input  logic [rmsn_pkg::NUM_W-1:0] num_i,
   input  logic [rmsn_pkg::MEAN_W-1:0] den_i,
   output logic                       done,
   output logic [rmsn_pkg::NUM_W-1:0] result
);
   import rmsn_pkg::*;

   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(NUM_W);
   localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(NUM_W / 2);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  res_ff, res_in;
   logic [MEAN_W-1:0] den_ff;
   logic [CNT_W-1:0]  steps_ff;
   logic              busy_ff, done_ff, op_ff;
   logic [REM_W-1:0]  shifted, trial;
   logic              fits;

   // One compare-and-subtract step, shared by both operations.
   always_comb begin
      if (op_ff == OP_SQRT) begin
         shifted = {rem_ff[REM_W-3:0], num_ff[NUM_W-1:NUM_W-2]};
         trial   = {res_ff, 2'b01};
         num_in  = {num_ff[NUM_W-3:0], 2'b00};
      end else begin
         shifted = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
         trial   = {{(REM_W-MEAN_W){1'b0}}, den_ff};
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
      end
      fits   = (shifted >= trial);
      rem_in = fits ? (shifted - trial) : shifted;
      res_in = {res_ff[NUM_W-2:0], fits};
   end

   // Step counter and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff  <= 1'b1;
            op_ff    <= cmd.op;
            num_ff   <= num_i;
            den_ff   <= den_i;
            rem_ff   <= '0;
            res_ff   <= '0;
            steps_ff <= (cmd.op == OP_SQRT) ? SQRT_STEPS : DIV_STEPS;
         end else if (busy_ff) begin
            num_ff   <= num_in;
            rem_ff   <= rem_in;
            res_ff   <= res_in;
            steps_ff <= steps_ff - 1'b1;
            if (steps_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== design/rms_row_normalizer_unit.sv =====
// RMS row normalizer. The row-end accumulate word runs two 58-step divides
// (sum by count and 2^56 by the mean) and a 29-step root, all on one shared
// unit. For a normalize word, the first product is registered in ST_MUL1 and
// the result register loads in ST_MUL2, later while an earlier result waits.
// One word is in flight at a time. Synchronous active-high reset clears the
// sum, count, scale and overflow flag and sets epsilon to 17.
// Depends on rmsn_pkg and rmsn_root_div_unit.
module rms_row_normalizer_unit #(
   parameter int MAX_ROW      = 8192,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   // Input channel.
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: sample [SAMPLE_WIDTH-1:0], channel_weight next 16 bits, zero pad.
   input  logic [((SAMPLE_WIDTH+16+7)/8)*8-1:0] req_tdata,
   // tuser: kind.
   input  logic req_tuser,
   input  logic req_tlast,
   // Result channel.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: normalized [SAMPLE_WIDTH-1:0], zero pad.
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // tuser: clipped.
   output logic rsp_tuser,
   output logic rsp_tlast,
   // Configuration: epsilon.
   input  logic csr_we,
   input  logic [rmsn_pkg::EPS_W-1:0] csr_wdata
);
   import rmsn_pkg::*;

   localparam int SW      = SAMPLE_WIDTH;
   localparam int CW      = $clog2(MAX_ROW + 1);
   localparam int SQ_W    = 2 * SW;
   localparam int ADD_W   = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
   localparam int P1_W    = SW + SCALE_W;
   localparam int T_W     = SW + 17;
   localparam int P2_W    = T_W + WEIGHT_W;
   localparam int R_W     = T_W + 5;
   localparam int OUT_DW  = ((SW + 7) / 8) * 8;
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ROW);
   localparam logic [SUM_W-1:0] SUM_CAP = {SUM_W{1'b1}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_ACC, ST_DIV1, ST_DIV2, ST_SQRT, ST_MUL1, ST_MUL2
   } state_type;

   state_type          state_ff;
   logic [EPS_W-1:0]   eps_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [CW-1:0]      count_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic               ovf_ff;
   logic [SW-1:0]      smag_ff;
   logic [WEIGHT_W-1:0] wmag_ff;
   logic               neg_ff, last_ff, counted_ff;
   logic [T_W-1:0]     t_ff;
   logic               rsp_valid_ff, rsp_last_ff, rsp_clip_ff;
   logic [SW-1:0]      rsp_data_ff;
   rmsn_cmd_type       cmd_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [MEAN_W-1:0]  den_ff;
   logic               unit_done;
   logic [NUM_W-1:0]   unit_res;

   logic               accept;
   logic [SW-1:0]      s_raw, s_mag;
   logic [WEIGHT_W-1:0] w_raw, w_mag;
   logic [SQ_W-1:0]    square;
   logic [ADD_W-1:0]   sum_wide;
   logic [SUM_W-1:0]   sum_next;
   logic               sum_sat;
   logic [SUM_W-1:0]   quot;
   logic [MEAN_W-1:0]  mean;
   logic [P1_W:0]      p1;
   logic [P2_W:0]      p2;
   logic [R_W-1:0]     r_mag, limit, r_sat;
   logic               r_clip;
   logic [SW-1:0]      r_val;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign s_raw      = req_tdata[SW-1:0];
   assign w_raw      = req_tdata[SW+WEIGHT_W-1:SW];
   assign s_mag      = s_raw[SW-1] ? (~s_raw + 1'b1) : s_raw;
   assign w_mag      = w_raw[WEIGHT_W-1] ? (~w_raw + 1'b1) : w_raw;

   // Square and saturating add to the running sum.
   always_comb begin
      square   = SQ_W'(smag_ff) * SQ_W'(smag_ff);
      sum_wide = ADD_W'(square) + ADD_W'(sum_ff);
      sum_sat  = (sum_wide > ADD_W'(SUM_CAP)) && counted_ff;
      if (!counted_ff) begin
         sum_next = sum_ff;
      end else if (sum_sat) begin
         sum_next = SUM_CAP;
      end else begin
         sum_next = sum_wide[SUM_W-1:0];
      end
   end

   // Mean plus epsilon, forced to one when zero.
   always_comb begin
      quot = (state_ff == ST_DIV1) ? unit_res[SUM_W-1:0] : '0;
      mean = MEAN_W'(quot) + MEAN_W'(eps_ff);
      if (mean == '0) begin
         mean = MEAN_W'(1);
      end
   end

   // Two rounded multiplies and saturation.
   always_comb begin
      p1     = (P1_W+1)'(smag_ff) * (P1_W+1)'(scale_ff) + (P1_W+1)'(1 << 15);
      p2     = (P2_W+1)'(t_ff) * (P2_W+1)'(wmag_ff) + (P2_W+1)'(1 << 11);
      r_mag  = p2[P2_W:12];
      limit  = neg_ff ? (R_W'(1) << (SW - 1)) : ((R_W'(1) << (SW - 1)) - 1'b1);
      r_clip = (r_mag > limit);
      r_sat  = r_clip ? limit : r_mag;
      r_val  = neg_ff ? (~r_sat[SW-1:0] + 1'b1) : r_sat[SW-1:0];
   end

   // Sequencer with datapath and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eps_ff       <= EPS_W'(17);
         sum_ff       <= '0;
         count_ff     <= '0;
         scale_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= '0;
      end else begin
         // A start pulse lasts one cycle; no new start is issued meanwhile.
         if (cmd_ff.start) begin
            cmd_ff.start <= 1'b0;
         end
         if (csr_we) begin
            eps_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_MUL2)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  smag_ff    <= s_mag;
                  wmag_ff    <= w_mag;
                  neg_ff     <= s_raw[SW-1] ^ w_raw[WEIGHT_W-1];
                  last_ff    <= req_tlast;
                  counted_ff <= (count_ff < COUNT_MAX);
                  if (count_ff >= COUNT_MAX) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                  end
                  state_ff <= req_tuser ? ST_MUL1 : ST_ACC;
               end
            end
            ST_ACC: begin
               if (sum_sat) begin
                  ovf_ff <= 1'b1;
               end
               if (!last_ff) begin
                  sum_ff   <= sum_next;
                  state_ff <= ST_IDLE;
               end else begin
                  sum_ff   <= '0;
                  count_ff <= '0;
                  cmd_ff   <= '{start: 1'b1, op: OP_DIV};
                  if (count_ff == '0) begin
                     num_ff   <= NUM_W'(1) << 56;
                     den_ff   <= mean;
                     state_ff <= ST_DIV2;
                  end else begin
                     num_ff   <= NUM_W'(sum_next);
                     den_ff   <= MEAN_W'(count_ff);
                     state_ff <= ST_DIV1;
                  end
               end
            end
            ST_DIV1: begin
               if (unit_done) begin
                  num_ff   <= NUM_W'(1) << 56;
                  den_ff   <= mean;
                  cmd_ff   <= '{start: 1'b1, op: OP_DIV};
                  state_ff <= ST_DIV2;
               end
            end
            ST_DIV2: begin
               if (unit_done) begin
                  num_ff   <= unit_res;
                  cmd_ff   <= '{start: 1'b1, op: OP_SQRT};
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               if (unit_done) begin
                  scale_ff <= unit_res[SCALE_W-1:0];
                  state_ff <= ST_IDLE;
               end
            end
            ST_MUL1: begin
               t_ff     <= p1[P1_W:16];
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= r_val;
                  rsp_last_ff  <= last_ff;
                  rsp_clip_ff  <= r_clip || ovf_ff;
                  if (last_ff) begin
                     count_ff <= '0;
                     ovf_ff   <= 1'b0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   rmsn_root_div_unit u_root_div (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd_ff),
      .num_i  (num_ff),
      .den_i  (den_ff),
      .done   (unit_done),
      .result (unit_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DW'(rsp_data_ff);
   assign rsp_tuser  = rsp_clip_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
